@@ hdl/base64_stream_encoder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit_macros
// Assertion macros shared by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE64_STREAM_ENCODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define B64SE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define B64SE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define B64SE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define B64SE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/b64se_pkg.sv @@
// ----------------------------------------------------------------------------
// b64se_pkg
// Types, constants and the character map of the Base64 stream encoder.
// ----------------------------------------------------------------------------
package b64se_pkg;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	localparam logic [7:0] PAD_CHAR   = 8'h3D; // '='
	localparam logic [7:0] PLUS_CHAR  = 8'h2B; // '+'
	localparam logic [7:0] SLASH_CHAR = 8'h2F; // '/'
	localparam logic [7:0] DASH_CHAR  = 8'h2D; // '-'
	localparam logic [7:0] UNDER_CHAR = 8'h5F; // '_'

	typedef struct packed {
		logic       pad;
		logic [5:0] val;
	} sym_t;

	// up to four characters produced by one byte
	typedef struct packed {
		sym_t [3:0] sym;
		logic [1:0] last_idx;
		logic       last;
	} job_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
		logic [7:0] w;
		logic [7:0] c;
		w = {2'b00, v};
		if (v < 6'd26)
			c = w + 8'h41;
		else if (v < 6'd52)
			c = w - 8'd26 + 8'h61;
		else if (v < 6'd62)
			c = w - 8'd52 + 8'h30;
		else if (v == 6'd62)
			c = url ? DASH_CHAR : PLUS_CHAR;
		else
			c = url ? UNDER_CHAR : SLASH_CHAR;
		return c;
	endfunction

endpackage

@@ hdl/b64se_front.sv @@
// ----------------------------------------------------------------------------
// b64se_front
// Accepts bytes, tracks the group phase and leftover bits, and builds the
// list of sextets and pads that each byte produces.
// ----------------------------------------------------------------------------
module b64se_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               q_full,
	output logic               push,
	output b64se_pkg::job_t    push_job
);

	logic [1:0] phase_q;
	logic [3:0] left_q;
	logic [1:0] phase_d;
	logic [3:0] left_d;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_job          = '0;
		push_job.last     = last_byte;
		phase_d           = b64se_pkg::PH_SECOND;
		left_d            = {2'b00, data_byte[1:0]};
		case (phase_q)
			b64se_pkg::PH_SECOND: begin
				push_job.sym[0].val = {left_q[1:0], data_byte[7:4]};
				push_job.sym[1].val = {data_byte[3:0], 2'b00};
				push_job.sym[2].pad = 1'b1;
				push_job.last_idx   = last_byte ? 2'd2 : 2'd0;
				phase_d             = b64se_pkg::PH_THIRD;
				left_d              = data_byte[3:0];
			end
			b64se_pkg::PH_THIRD: begin
				push_job.sym[0].val = {left_q, data_byte[7:6]};
				push_job.sym[1].val = data_byte[5:0];
				push_job.last_idx   = 2'd1;
				phase_d             = b64se_pkg::PH_FIRST;
				left_d              = 4'd0;
			end
			default: begin
				push_job.sym[0].val = data_byte[7:2];
				push_job.sym[1].val = {data_byte[1:0], 4'b0000};
				push_job.sym[2].pad = 1'b1;
				push_job.sym[3].pad = 1'b1;
				push_job.last_idx   = last_byte ? 2'd3 : 2'd0;
			end
		endcase
		if (last_byte) begin
			phase_d = b64se_pkg::PH_FIRST;
			left_d  = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64se_pkg::PH_FIRST;
			left_q  <= 4'd0;
		end else if (push) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

@@ hdl/b64se_queue.sv @@
// ----------------------------------------------------------------------------
// b64se_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_unit_macros.svh"

module b64se_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b64se_pkg::job_t    push_job,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output b64se_pkg::job_t    head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64se_pkg::job_t  slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`B64SE_ASSERT_IMP(a_no_overflow, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`B64SE_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !empty)
	`B64SE_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full)

endmodule

@@ hdl/b64se_back.sv @@
// ----------------------------------------------------------------------------
// b64se_back
// Walks the characters of each job and emits one per cycle, while out_stall
// is low, through an output register.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_unit_macros.svh"

module b64se_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               url_alphabet,
	input  logic               q_empty,
	input  b64se_pkg::job_t    head_job,
	output logic               pop,
	output logic [7:0]         out_char,
	output logic               last_char,
	output logic               out_valid,
	input  logic               out_stall
);

	b64se_pkg::job_t job_q;
	logic            job_valid_q;
	logic [1:0]      idx_q;
	logic            load;
	logic            at_end;
	b64se_pkg::sym_t cur_sym;
	logic [7:0]      cur_char;

	assign cur_sym  = job_q.sym[idx_q];
	assign cur_char = cur_sym.pad ? b64se_pkg::PAD_CHAR
	                              : b64se_pkg::sextet_char(cur_sym.val, url_alphabet);
	assign load     = job_valid_q && (!out_valid || !out_stall);
	assign at_end   = (idx_q == job_q.last_idx);
	assign pop      = !q_empty && (!job_valid_q || (load && at_end));

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head_job;
		if (load) begin
			out_char  <= cur_char;
			last_char <= at_end && job_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid   <= 1'b0;
		end else begin
			if (pop)
				job_valid_q <= 1'b1;
			else if (load && at_end)
				job_valid_q <= 1'b0;
			if (load)
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	`B64SE_ASSERT_IMP(a_idx_in_job, clk, arst_n, job_valid_q, idx_q <= job_q.last_idx)
	`B64SE_ASSERT_NXT(a_idx_restart, clk, arst_n, load && at_end, idx_q == 2'd0)
	`B64SE_ASSERT_IMP(a_idle_idx, clk, arst_n, !job_valid_q, idx_q == 2'd0)

endmodule

@@ hdl/base64_stream_encoder_unit.sv @@
// Path: a byte's job passes the job queue, the job register and the output register.
// Throughput: one character per cycle out of the output register while not stalled;
// bytes are taken every cycle while the job queue (QUEUE_DEPTH entries) has room, so the
// output rate of four characters per three bytes sets the sustained byte rate.
// Reset: arst_n clears the phase, leftover bits, queue, output valid and selects the
// standard alphabet.
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// Streaming Base64 encoder, one byte in and one character out per item.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       in_valid,
	output logic       in_stall,
	output logic [7:0] out_char,
	output logic       last_char,
	output logic       out_valid,
	input  logic       out_stall
);

	logic            url_alphabet_q;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	b64se_pkg::job_t push_job;
	b64se_pkg::job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			url_alphabet_q <= 1'b0;
		else if (cfg_wr_en)
			url_alphabet_q <= cfg_wr_data;
	end

	b64se_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	b64se_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head_job (head_job)
	);

	b64se_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.url_alphabet (url_alphabet_q),
		.q_empty      (q_empty),
		.head_job     (head_job),
		.pop          (pop),
		.out_char     (out_char),
		.last_char    (last_char),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

endmodule
